// ===== rtl/rat_pkg.sv =====
package rat_pkg;

	// Default sizes of the tracker.
	localparam int CHANNELS_DEF      = 8;
	localparam int PENDING_DEPTH_DEF = 256;
	localparam int MAX_PACKET_DEF    = 1400;

	// Fixed protocol constants.
	localparam int          HEADER_BYTES = 14;
	localparam int          ACK_WINDOW   = 32;
	localparam logic [15:0] HALF_RANGE   = 16'd32767;
	localparam int          COUNT_W      = 9;

	// Item kinds.
	localparam logic ACT_SEND = 1'b0;
	localparam logic ACT_RECV = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_PAYLOAD     = 3'd1,
		ST_SHORT       = 3'd2,
		ST_PROTO       = 3'd3,
		ST_BAD_CHANNEL = 3'd4,
		ST_FULL        = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic recv_go;
		logic rd_left;
		logic inflight;
	} sts_t;

	// True when sequence a is newer than b, modulo 65536.
	function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d_ab;
		logic [15:0] d_ba;
		d_ab = a - b;
		d_ba = b - a;
		return ((a > b) && (d_ab <= HALF_RANGE)) || ((a < b) && (d_ba > HALF_RANGE));
	endfunction

	// True when sequence s is acknowledged by ack or by one of the ack bits.
	function automatic logic is_acked(input logic [15:0] s, input logic [15:0] ack,
			input logic [31:0] bits);
		logic [15:0] diff;
		logic [4:0]  pos;
		diff = ack - s;
		pos  = diff[4:0] - 5'd1;
		return (diff == 16'd0) || ((diff < 16'(ACK_WINDOW)) && bits[pos]);
	endfunction

endpackage

// ===== rtl/rat_ram.sv =====
module rat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rat_ctrl.sv =====
module rat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output rat_pkg::cmd_t cmd,
	input  rat_pkg::sts_t sts
);

	import rat_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.recv_go ? S_WALK : S_FINISH;
			end
			S_WALK: begin
				if (!sts.rd_left && !sts.inflight) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		busy          = (state_q != S_IDLE);
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.walk_init = (state_q == S_CHECK) && sts.recv_go;
		cmd.walk      = (state_q == S_WALK);
		cmd.finish    = (state_q == S_FINISH);
	end

endmodule

// ===== rtl/rat_dp.sv =====
module rat_dp #(
	parameter int CHANNELS      = rat_pkg::CHANNELS_DEF,
	parameter int PENDING_DEPTH = rat_pkg::PENDING_DEPTH_DEF,
	parameter int MAX_PACKET    = rat_pkg::MAX_PACKET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rat_pkg::cmd_t                 cmd,
	output rat_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [15:0]                   cfg_wdata,
	input  logic                          action,
	input  logic [7:0]                    channel,
	input  logic                          reliable,
	input  logic [15:0]                   data_bytes,
	input  logic [15:0]                   packet_length,
	input  logic [15:0]                   header_protocol,
	input  logic [15:0]                   header_sequence,
	input  logic [15:0]                   header_ack,
	input  logic [31:0]                   header_ack_bits,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [15:0]                   sequence_out,
	output logic [15:0]                   ack_out,
	output logic [rat_pkg::COUNT_W-1:0]   pending_entries,
	output logic [rat_pkg::COUNT_W-1:0]   cleared_entries
);

	import rat_pkg::*;

	localparam int          CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int          PL_W      = $clog2(PENDING_DEPTH + 1);
	localparam int          MEM_DEPTH = CHANNELS * PENDING_DEPTH;
	localparam int          AW        = $clog2(MEM_DEPTH);
	localparam logic [15:0] MAX_SIZE  = 16'(MAX_PACKET - HEADER_BYTES);

	// Captured item.
	logic        act_q;
	logic [7:0]  ch_q;
	logic        rel_q;
	logic [15:0] psize_q;
	logic [15:0] plen_q;
	logic [15:0] hproto_q;
	logic [15:0] hseq_q;
	logic [15:0] hack_q;
	logic [31:0] hbits_q;

	// Per-channel state and the protocol register.
	logic [15:0]     protocol_id_q;
	logic [15:0]     local_seq_q  [CHANNELS];
	logic [15:0]     remote_seq_q [CHANNELS];
	logic [PL_W-1:0] pending_len_q[CHANNELS];

	// Walk counters.
	logic [PL_W-1:0] r_q;
	logic [PL_W-1:0] w_q;
	logic            rd_valid_s1;

	logic            ch_ok;
	logic [CH_W-1:0] chi;
	logic [15:0]     loc_cur;
	logic [15:0]     rem_cur;
	logic [PL_W-1:0] len_cur;
	status_t         chk_status;
	logic            send_take;
	logic            push;
	logic            recv_ok;
	logic [PL_W-1:0] len_new;
	logic [15:0]     rem_new;
	logic [PL_W-1:0] cleared;
	logic [AW-1:0]   base;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_rdata;
	logic            keep;

	// Protocol register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_id_q <= '0;
		end else if (cfg_we) begin
			protocol_id_q <= cfg_wdata;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			ch_q     <= channel;
			rel_q    <= reliable;
			psize_q  <= data_bytes;
			plen_q   <= packet_length;
			hproto_q <= header_protocol;
			hseq_q   <= header_sequence;
			hack_q   <= header_ack;
			hbits_q  <= header_ack_bits;
		end
	end

	// Channel selection and current channel state.
	always_comb begin
		ch_ok   = (ch_q < 8'(CHANNELS));
		chi     = ch_q[CH_W-1:0];
		loc_cur = local_seq_q[chi];
		rem_cur = remote_seq_q[chi];
		len_cur = pending_len_q[chi];
		base    = AW'(chi) * AW'(PENDING_DEPTH);
	end

	// Checks in the order of the protocol.
	always_comb begin
		chk_status = ST_OK;
		if (act_q == ACT_SEND) begin
			if (psize_q > MAX_SIZE) begin
				chk_status = ST_PAYLOAD;
			end else if (!ch_ok) begin
				chk_status = ST_BAD_CHANNEL;
			end else if (rel_q && (len_cur >= PL_W'(PENDING_DEPTH))) begin
				chk_status = ST_FULL;
			end
		end else begin
			if (plen_q < 16'(HEADER_BYTES)) begin
				chk_status = ST_SHORT;
			end else if (hproto_q != protocol_id_q) begin
				chk_status = ST_PROTO;
			end else if (!ch_ok) begin
				chk_status = ST_BAD_CHANNEL;
			end
		end
	end

	// State after the item.
	always_comb begin
		send_take = (act_q == ACT_SEND) && ((chk_status == ST_OK) || (chk_status == ST_FULL));
		push      = send_take && rel_q && (chk_status == ST_OK);
		recv_ok   = (act_q == ACT_RECV) && (chk_status == ST_OK);
		len_new   = len_cur;
		if (push) begin
			len_new = len_cur + PL_W'(1);
		end else if (recv_ok) begin
			len_new = w_q;
		end
		rem_new = (recv_ok && seq_newer(hseq_q, rem_cur)) ? hseq_q : rem_cur;
		cleared = recv_ok ? (len_cur - w_q) : '0;
	end

	// Status to the controller.
	always_comb begin
		sts.recv_go  = recv_ok;
		sts.rd_left  = (r_q < len_cur);
		sts.inflight = rd_valid_s1;
	end

	// Memory access: the walk reads one entry a cycle and writes back the kept ones; a reliable send appends at finish.
	always_comb begin
		keep      = rd_valid_s1 && !is_acked(ram_rdata, hack_q, hbits_q);
		ram_re    = cmd.walk && sts.rd_left;
		ram_raddr = base + AW'(r_q);
		ram_we    = keep || (cmd.finish && push);
		ram_waddr = base + (keep ? AW'(w_q) : AW'(len_cur));
		ram_wdata = keep ? ram_rdata : loc_cur;
	end

	// Walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= '0;
			w_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.walk_init) begin
			r_q         <= '0;
			w_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ram_re;
			if (ram_re) begin
				r_q <= r_q + PL_W'(1);
			end
			if (keep) begin
				w_q <= w_q + PL_W'(1);
			end
		end
	end

	// Per-channel state update at the end of an item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				local_seq_q[i]   <= '0;
				remote_seq_q[i]  <= '0;
				pending_len_q[i] <= '0;
			end
		end else if (cmd.finish && ch_ok) begin
			if (send_take) begin
				local_seq_q[chi] <= loc_cur + 16'd1;
			end
			remote_seq_q[chi]  <= rem_new;
			pending_len_q[chi] <= len_new;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status          <= chk_status;
			sequence_out    <= send_take ? loc_cur : 16'd0;
			ack_out         <= ch_ok ? rem_new : 16'd0;
			pending_entries <= ch_ok ? COUNT_W'(len_new) : '0;
			cleared_entries <= COUNT_W'(cleared);
		end
	end

	rat_ram #(
		.WIDTH(16),
		.DEPTH(MEM_DEPTH)
	) u_pending_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== rtl/reliable_ack_tracker_top.sv =====
// A send or a rejected item passes the check and finish states, then shows its result;
// an accepted receive also walks the channel's pending list between those states,
// reading one pending entry per cycle through the pending RAM.
// A new item is taken in the cycle a result is shown; one item is in work at a time.
// Reset (arst_n low) clears sequences, pending lengths and the protocol register at once;
// the pending RAM is not cleared. The receiver cannot stall: done is a one-cycle strobe.
module reliable_ack_tracker_top #(
	parameter int CHANNELS      = rat_pkg::CHANNELS_DEF,
	parameter int PENDING_DEPTH = rat_pkg::PENDING_DEPTH_DEF,
	parameter int MAX_PACKET    = rat_pkg::MAX_PACKET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [7:0]                  channel,
	input  logic                        reliable,
	input  logic [15:0]                 data_bytes,
	input  logic [15:0]                 packet_length,
	input  logic [15:0]                 header_protocol,
	input  logic [15:0]                 header_sequence,
	input  logic [15:0]                 header_ack,
	input  logic [31:0]                 header_ack_bits,
	input  logic                        cfg_we,
	input  logic [15:0]                 cfg_wdata,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [15:0]                 sequence_out,
	output logic [15:0]                 ack_out,
	output logic [rat_pkg::COUNT_W-1:0] pending_entries,
	output logic [rat_pkg::COUNT_W-1:0] cleared_entries
);

	import rat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller.
	rat_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.sts   (sts)
	);

	// Datapath with the pending RAM.
	rat_dp #(
		.CHANNELS     (CHANNELS),
		.PENDING_DEPTH(PENDING_DEPTH),
		.MAX_PACKET   (MAX_PACKET)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.action         (action),
		.channel        (channel),
		.reliable       (reliable),
		.data_bytes     (data_bytes),
		.packet_length  (packet_length),
		.header_protocol(header_protocol),
		.header_sequence(header_sequence),
		.header_ack     (header_ack),
		.header_ack_bits(header_ack_bits),
		.done           (done),
		.status         (status),
		.sequence_out   (sequence_out),
		.ack_out        (ack_out),
		.pending_entries(pending_entries),
		.cleared_entries(cleared_entries)
	);

endmodule

// ===== rtl/rat_checker.sv =====
module rat_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [2:0]                  status,
	input logic [15:0]                 sequence_out,
	input logic [15:0]                 ack_out,
	input logic [rat_pkg::COUNT_W-1:0] pending_entries
);

	import rat_pkg::*;

	// A taken item keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an item was taken");

	// A result is shown only when the block is free again, and never twice in a row.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy ##1 !done))
		else $error("result strobe while busy or held for two cycles");

	// Rejected items carry no sequence.
	a_reject_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK) && (status != ST_FULL)) |-> (sequence_out == 16'd0))
		else $error("rejected item reports a sequence");

	// A bad channel reports no channel state.
	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_BAD_CHANNEL)) |-> ((ack_out == 16'd0) && (pending_entries == '0)))
		else $error("bad channel reports channel state");

	// Status codes stay within the defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_FULL))
		else $error("undefined status code");

endmodule

bind reliable_ack_tracker_top rat_checker u_rat_checker (.*);
